// ----- src/chs_lba_geometry_translator_macros.svh -----
// Assertion macros shared by the address translator RTL.
`ifndef CHS_LBA_GEOMETRY_TRANSLATOR_MACROS_SVH
`define CHS_LBA_GEOMETRY_TRANSLATOR_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define CLGT_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("clgt: same-cycle check failed");

// Next-cycle implication, checked only out of reset.
`define CLGT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("clgt: next-cycle check failed");

`endif

// ----- src/clgt_pkg.sv -----
// Types and constants for the CHS/LBA geometry translator.
package clgt_pkg;

  localparam int unsigned LBA_W     = 32;
  localparam int unsigned CHS_W     = 16;
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CHS_W-1:0] RST_CYLINDERS = 16'd1024;
  localparam logic [CHS_W-1:0] RST_HEADS     = 16'd255;
  localparam logic [CHS_W-1:0] RST_SECTORS   = 16'd63;
  localparam logic [LBA_W-1:0] MIN_ALIGN     = 32'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CYLINDERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTORS   = 2'd2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TO_CHS = 2'd0,
    FUNC_TO_LBA = 2'd1,
    FUNC_ADJUST = 2'd2,
    FUNC_ALIGN  = 2'd3
  } func_e;

  // Divider status toward the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- src/chs_lba_geometry_translator.sv -----
// Top level: CHS/LBA address translator with a shared divider and multiplier.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o) takes one item: an op code and
//    its operands. Output channel (out_valid_o / out_stall_i) returns exactly
//    one result item per input item, in order.
//  - Geometry registers (cylinders, heads, sectors per track) are written
//    through cfg_we_i / cfg_idx_i / cfg_data_i; the user must do this only
//    while the block is idle, as the block itself does not enforce it.
//  - One item at a time: in_stall_o is high from acceptance until the result
//    is moved into the output register; the next item can be taken in the
//    cycle after. Work done per op:
//      op 0 (lba to chs): two divides, clamp, fold loop; faults if heads*spt=0
//      op 1 (chs to lba): two passes through the 32x16 multiplier
//      op 2 (adjust chs): clamp plus fold loop
//      op 3 (align up)  : one divide; faults if the effective alignment is 0
//  - A stalled receiver keeps the result in the output register; the block
//    still finishes the next item, then holds it until the register frees.
//  - Reset loads the default geometry 1024/255/63 and clears all control.
`include "chs_lba_geometry_translator_macros.svh"

module chs_lba_geometry_translator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config write port
  input  logic                             cfg_we_i,
  input  logic [clgt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [clgt_pkg::CHS_W-1:0]       cfg_data_i,
  // input items
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [clgt_pkg::FUNC_W-1:0]      func_i,
  input  logic [clgt_pkg::LBA_W-1:0]       lba_in_i,
  input  logic [clgt_pkg::CHS_W-1:0]       cylinder_in_i,
  input  logic [clgt_pkg::CHS_W-1:0]       head_in_i,
  input  logic [clgt_pkg::CHS_W-1:0]       sector_in_i,
  input  logic [clgt_pkg::LBA_W-1:0]       alignment_i,
  // result items
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [clgt_pkg::LBA_W-1:0]       lba_out_o,
  output logic [clgt_pkg::CHS_W-1:0]       cylinder_out_o,
  output logic [clgt_pkg::CHS_W-1:0]       head_out_o,
  output logic [clgt_pkg::CHS_W-1:0]       sector_out_o,
  output logic                             range_error_o,
  output logic                             divide_fault_o
);
  import clgt_pkg::*;

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_TRK    = 4'd1;   // track size = heads * spt
  localparam logic [3:0] S_TRKCHK = 4'd2;   // zero check, start lba / track
  localparam logic [3:0] S_DIV1   = 4'd3;   // wait cylinder divide
  localparam logic [3:0] S_DIV2   = 4'd4;   // wait head/sector divide
  localparam logic [3:0] S_FIT    = 4'd5;   // clamp sector and head
  localparam logic [3:0] S_FOLD   = 4'd6;   // halve cylinder, double head
  localparam logic [3:0] S_CH1    = 4'd7;   // cyl * heads
  localparam logic [3:0] S_CH2    = 4'd8;   // + head
  localparam logic [3:0] S_CH3    = 4'd9;   // * spt
  localparam logic [3:0] S_CH4    = 4'd10;  // + sector - 1
  localparam logic [3:0] S_ALN    = 4'd11;  // pick alignment, start divide
  localparam logic [3:0] S_DIV3   = 4'd12;  // wait remainder, round up
  localparam logic [3:0] S_DONE   = 4'd13;  // hand result to output register

  logic [3:0] state_q, state_d;

  // geometry
  logic [CHS_W-1:0] cyl_cfg_q, cyl_cfg_d;
  logic [CHS_W-1:0] heads_q, heads_d;
  logic [CHS_W-1:0] spt_q, spt_d;

  // latched operands
  func_e            func_q, func_d;
  logic [LBA_W-1:0] lba_q, lba_d;
  logic [LBA_W-1:0] aln_q, aln_d;
  logic [CHS_W-1:0] cyl_in_q, cyl_in_d;
  logic [CHS_W-1:0] head_in_q, head_in_d;
  logic [CHS_W-1:0] sect_in_q, sect_in_d;

  // working results
  logic [CHS_W-1:0] c_q, c_d;
  logic [CHS_W-1:0] h_q, h_d;
  logic [CHS_W-1:0] s_q, s_d;
  logic [LBA_W-1:0] res_q, res_d;
  logic [LBA_W-1:0] mul_q, mul_d;
  logic             rerr_q, rerr_d;
  logic             fault_q, fault_d;

  // output register
  logic             out_valid_q, out_valid_d;
  logic [LBA_W-1:0] out_lba_q, out_lba_d;
  logic [CHS_W-1:0] out_c_q, out_c_d;
  logic [CHS_W-1:0] out_h_q, out_h_d;
  logic [CHS_W-1:0] out_s_q, out_s_d;
  logic             out_rerr_q, out_rerr_d;
  logic             out_fault_q, out_fault_d;

  // shared multiplier, 32x16, low word kept
  logic [LBA_W-1:0]       mul_a;
  logic [CHS_W-1:0]       mul_b;
  logic [LBA_W+CHS_W-1:0] mul_full;
  logic [LBA_W-1:0]       mul_p;

  assign mul_full = mul_a * mul_b;
  assign mul_p    = mul_full[LBA_W-1:0];

  // shared divider
  logic             div_start;
  logic [LBA_W-1:0] div_dvd;
  logic [LBA_W-1:0] div_dvs;
  logic [LBA_W-1:0] div_quo;
  logic [LBA_W-1:0] div_rem;
  div_stat_t        div_stat;

  clgt_div #(
    .W (LBA_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dvs),
    .quotient_o  (div_quo),
    .remainder_o (div_rem),
    .stat_o      (div_stat)
  );

  logic [CHS_W:0]   h_dbl;
  logic [LBA_W-1:0] eff_aln;

  assign h_dbl   = {h_q, 1'b0};
  assign eff_aln = (aln_q < MIN_ALIGN) ? {{(LBA_W-CHS_W){1'b0}}, spt_q} : aln_q;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    cyl_cfg_d   = cyl_cfg_q;
    heads_d     = heads_q;
    spt_d       = spt_q;
    func_d      = func_q;
    lba_d       = lba_q;
    aln_d       = aln_q;
    cyl_in_d    = cyl_in_q;
    head_in_d   = head_in_q;
    sect_in_d   = sect_in_q;
    c_d         = c_q;
    h_d         = h_q;
    s_d         = s_q;
    res_d       = res_q;
    mul_d       = mul_q;
    rerr_d      = rerr_q;
    fault_d     = fault_q;
    out_valid_d = out_valid_q;
    out_lba_d   = out_lba_q;
    out_c_d     = out_c_q;
    out_h_d     = out_h_q;
    out_s_d     = out_s_q;
    out_rerr_d  = out_rerr_q;
    out_fault_d = out_fault_q;
    mul_a       = {{(LBA_W-CHS_W){1'b0}}, heads_q};
    mul_b       = spt_q;
    div_start   = 1'b0;
    div_dvd     = lba_q;
    div_dvs     = mul_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CYLINDERS: cyl_cfg_d = cfg_data_i;
        CFG_HEADS:     heads_d   = cfg_data_i;
        CFG_SECTORS:   spt_d     = cfg_data_i;
        default: ;
      endcase
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d    = func_e'(func_i);
          lba_d     = lba_in_i;
          aln_d     = alignment_i;
          cyl_in_d  = cylinder_in_i;
          head_in_d = head_in_i;
          sect_in_d = sector_in_i;
          res_d     = '0;
          rerr_d    = 1'b0;
          fault_d   = 1'b0;
          c_d       = '0;
          h_d       = '0;
          s_d       = '0;
          case (func_e'(func_i))
            FUNC_TO_CHS: state_d = S_TRK;
            FUNC_TO_LBA: state_d = S_CH1;
            FUNC_ADJUST: begin
              c_d     = cylinder_in_i;
              h_d     = head_in_i;
              s_d     = sector_in_i;
              state_d = S_FIT;
            end
            default:     state_d = S_ALN;
          endcase
        end
      end
      S_TRK: begin
        mul_d   = mul_p;
        state_d = S_TRKCHK;
      end
      S_TRKCHK: begin
        if (mul_q == '0) begin
          fault_d = 1'b1;
          state_d = S_DONE;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_stat.done) begin
          c_d       = div_quo[CHS_W-1:0];
          div_start = 1'b1;
          div_dvd   = div_rem;
          div_dvs   = {{(LBA_W-CHS_W){1'b0}}, spt_q};
          state_d   = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_stat.done) begin
          h_d     = div_quo[CHS_W-1:0];
          s_d     = div_rem[CHS_W-1:0] + CHS_W'(1);
          state_d = S_FIT;
        end
      end
      S_FIT: begin
        s_d = (s_q > spt_q) ? spt_q : s_q;
        if (heads_q == '0) begin
          h_d = '0;
        end else if (h_q >= heads_q) begin
          h_d = heads_q - CHS_W'(1);
        end
        if (cyl_cfg_q == '0) begin
          c_d = '0;
        end
        state_d = S_FOLD;
      end
      S_FOLD: begin
        if (cyl_cfg_q == '0 || c_q < cyl_cfg_q) begin
          state_d = S_DONE;
        end else if (h_dbl > {1'b0, heads_q}) begin
          // head would overflow: pin to the last CHS of the geometry
          s_d = spt_q;
          h_d = heads_q - CHS_W'(1);
          c_d = cyl_cfg_q - CHS_W'(1);
        end else begin
          h_d = h_dbl[CHS_W-1:0];
          c_d = c_q >> 1;
        end
      end
      S_CH1: begin
        mul_a   = {{(LBA_W-CHS_W){1'b0}}, cyl_in_q};
        mul_b   = heads_q;
        mul_d   = mul_p;
        rerr_d  = (cyl_in_q >= cyl_cfg_q) || (head_in_q >= heads_q) ||
                  (sect_in_q > spt_q) || (sect_in_q == '0);
        state_d = S_CH2;
      end
      S_CH2: begin
        mul_d   = mul_q + {{(LBA_W-CHS_W){1'b0}}, head_in_q};
        state_d = S_CH3;
      end
      S_CH3: begin
        mul_a   = mul_q;
        mul_b   = spt_q;
        mul_d   = mul_p;
        state_d = S_CH4;
      end
      S_CH4: begin
        res_d   = mul_q + {{(LBA_W-CHS_W){1'b0}}, sect_in_q} - LBA_W'(1);
        state_d = S_DONE;
      end
      S_ALN: begin
        if (eff_aln == '0) begin
          fault_d = 1'b1;
          state_d = S_DONE;
        end else begin
          aln_d     = eff_aln;
          div_start = 1'b1;
          div_dvd   = lba_q;
          div_dvs   = eff_aln;
          state_d   = S_DIV3;
        end
      end
      S_DIV3: begin
        if (div_stat.done) begin
          res_d   = (div_rem != '0) ? (aln_q + lba_q - div_rem) : lba_q;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_lba_d   = res_q;
          out_c_d     = c_q;
          out_h_d     = h_q;
          out_s_d     = s_q;
          out_rerr_d  = rerr_q;
          out_fault_d = fault_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cyl_cfg_q   <= RST_CYLINDERS;
      heads_q     <= RST_HEADS;
      spt_q       <= RST_SECTORS;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cyl_cfg_q   <= cyl_cfg_d;
      heads_q     <= heads_d;
      spt_q       <= spt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    lba_q       <= lba_d;
    aln_q       <= aln_d;
    cyl_in_q    <= cyl_in_d;
    head_in_q   <= head_in_d;
    sect_in_q   <= sect_in_d;
    c_q         <= c_d;
    h_q         <= h_d;
    s_q         <= s_d;
    res_q       <= res_d;
    mul_q       <= mul_d;
    rerr_q      <= rerr_d;
    fault_q     <= fault_d;
    out_lba_q   <= out_lba_d;
    out_c_q     <= out_c_d;
    out_h_q     <= out_h_d;
    out_s_q     <= out_s_d;
    out_rerr_q  <= out_rerr_d;
    out_fault_q <= out_fault_d;
  end

  assign out_valid_o    = out_valid_q;
  assign lba_out_o      = out_lba_q;
  assign cylinder_out_o = out_c_q;
  assign head_out_o     = out_h_q;
  assign sector_out_o   = out_s_q;
  assign range_error_o  = out_rerr_q;
  assign divide_fault_o = out_fault_q;

  // A faulted item carries an all-zero payload.
  `CLGT_ASSERT(a_fault_zero, out_valid_o && divide_fault_o, lba_out_o == '0 && cylinder_out_o == '0 && head_out_o == '0 && sector_out_o == '0 && !range_error_o)
  // Divider results arrive only while the sequencer waits for them.
  `CLGT_ASSERT(a_div_done_wait, div_stat.done, state_q == S_DIV1 || state_q == S_DIV2 || state_q == S_DIV3)
  // No division runs while the block is idle.
  `CLGT_ASSERT(a_idle_div_quiet, state_q == S_IDLE, !div_stat.busy)
  // Fold loop exits once the cylinder fits.
  `CLGT_ASSERT_NEXT(a_fold_exit, state_q == S_FOLD && (cyl_cfg_q == '0 || c_q < cyl_cfg_q), state_q == S_DONE)
  // An accepted item holds off the next one.
  `CLGT_ASSERT_NEXT(a_accept_busy, in_valid_i && !in_stall_o, in_stall_o)

endmodule

// ----- src/clgt_div.sv -----
// Restoring divider, one quotient bit per cycle.
module clgt_div #(
  parameter int unsigned W = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [W-1:0]          dividend_i,
  input  logic [W-1:0]          divisor_i,
  output logic [W-1:0]          quotient_o,
  output logic [W-1:0]          remainder_o,
  output clgt_pkg::div_stat_t   stat_o
);
  import clgt_pkg::*;

  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    quo_q, quo_d;
  logic [W-1:0]    dvs_q, dvs_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;

  logic [W:0] trial;
  logic [W:0] diff;
  logic       fits;

  assign trial = {rem_q, quo_q[W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[W-1:0] : trial[W-1:0];
      quo_d = {quo_q[W-2:0], fits};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ----- tb/sv/chs_lba_geometry_translator_tb.sv -----
// Self-checking testbench for the CHS/LBA geometry translator.
module chs_lba_geometry_translator_tb;
  import clgt_pkg::*;

  // No acceptance on either channel for this many cycles ends the run.
  // The worst correct stretch is the long output hold (LONG_HOLD) plus one
  // slow op 0 item and the random gaps and stalls.
  localparam int unsigned IDLE_LIMIT = 5000;
  // Length of the deliberate output hold that fills the block.
  localparam int unsigned LONG_HOLD  = 400;

  // One input item and one result item, at the port widths.
  typedef struct {
    func_e             func;
    logic [LBA_W-1:0]  lba;
    logic [CHS_W-1:0]  cyl;
    logic [CHS_W-1:0]  head;
    logic [CHS_W-1:0]  sect;
    logic [LBA_W-1:0]  align;
  } addr_req_t;

  typedef struct {
    logic [LBA_W-1:0]  lba;
    logic [CHS_W-1:0]  cyl;
    logic [CHS_W-1:0]  head;
    logic [CHS_W-1:0]  sect;
    logic              range_err;
    logic              fault;
  } addr_rsp_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CHS_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [FUNC_W-1:0]  func_drv = '0;
  logic [LBA_W-1:0]   lba_drv = '0;
  logic [CHS_W-1:0]   cyl_drv = '0;
  logic [CHS_W-1:0]   head_drv = '0;
  logic [CHS_W-1:0]   sect_drv = '0;
  logic [LBA_W-1:0]   align_drv = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [LBA_W-1:0]   lba_out;
  logic [CHS_W-1:0]   cyl_out;
  logic [CHS_W-1:0]   head_out;
  logic [CHS_W-1:0]   sect_out;
  logic               range_err_out;
  logic               fault_out;

  // Local copy of the geometry registers; starts at the reset geometry.
  logic [CHS_W-1:0]   geo_cyls  = RST_CYLINDERS;
  logic [CHS_W-1:0]   geo_heads = RST_HEADS;
  logic [CHS_W-1:0]   geo_spt   = RST_SECTORS;

  addr_rsp_t          pending_results[$];
  int unsigned        mismatch_count = 0;
  bit                 no_idle = 1'b0;        // both sides run without gaps
  bit                 long_hold_req = 1'b0;  // receiver does one long hold

  chs_lba_geometry_translator dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (func_drv),
    .lba_in_i       (lba_drv),
    .cylinder_in_i  (cyl_drv),
    .head_in_i      (head_drv),
    .sector_in_i    (sect_drv),
    .alignment_i    (align_drv),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .lba_out_o      (lba_out),
    .cylinder_out_o (cyl_out),
    .head_out_o     (head_out),
    .sector_out_o   (sect_out),
    .range_error_o  (range_err_out),
    .divide_fault_o (fault_out)
  );

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Clamp sector and head to the geometry, then fold an oversized cylinder:
  // halve the cylinder while doubling the head, or pin to the last CHS when
  // the doubled head would go past the head count. Returns {cyl, head, sect}.
  function automatic logic [3*CHS_W-1:0] fit_geometry(input logic [CHS_W-1:0] c_in,
                                                      input logic [CHS_W-1:0] h_in,
                                                      input logic [CHS_W-1:0] s_in);
    logic [CHS_W-1:0] c;
    logic [CHS_W-1:0] h;
    logic [CHS_W-1:0] s;
    c = c_in;
    h = h_in;
    s = s_in;
    if (s > geo_spt) s = geo_spt;
    if (geo_heads == 0) h = '0;
    else if (h >= geo_heads) h = geo_heads - 1'b1;
    if (geo_cyls == 0) begin
      c = '0;
    end else begin
      while (c >= geo_cyls) begin
        if ((17'(h) << 1) > 17'(geo_heads)) begin
          s = geo_spt;
          h = geo_heads - 1'b1;
          c = geo_cyls - 1'b1;
        end else begin
          h = h << 1;
          c = c >> 1;
        end
      end
    end
    return {c, h, s};
  endfunction

  function automatic addr_rsp_t translate_addr(input addr_req_t req);
    addr_rsp_t   rsp;
    logic [63:0] track;
    logic [63:0] quo;
    logic [63:0] rem;
    logic [63:0] hd;
    logic [63:0] acc;
    rsp.lba       = '0;
    rsp.cyl       = '0;
    rsp.head      = '0;
    rsp.sect      = '0;
    rsp.range_err = 1'b0;
    rsp.fault     = 1'b0;
    case (req.func)
      FUNC_TO_CHS: begin
        track = 64'(geo_heads) * 64'(geo_spt);
        if (track == 0) begin
          rsp.fault = 1'b1;
        end else begin
          quo = 64'(req.lba) / track;
          rem = 64'(req.lba) - quo * track;
          hd  = rem / 64'(geo_spt);
          rem = rem - hd * 64'(geo_spt);
          acc = rem + 64'd1;
          {rsp.cyl, rsp.head, rsp.sect} = fit_geometry(quo[15:0], hd[15:0], acc[15:0]);
        end
      end
      FUNC_TO_LBA: begin
        // LBA is still produced for out-of-range operands; wraps at 2^32.
        rsp.range_err = (req.cyl >= geo_cyls) || (req.head >= geo_heads) ||
                        (req.sect > geo_spt) || (req.sect == 0);
        acc = 64'(req.sect) + 64'hFFFF_FFFF +
              (64'(req.cyl) * 64'(geo_heads) + 64'(req.head)) * 64'(geo_spt);
        rsp.lba = acc[31:0];
      end
      FUNC_ADJUST: begin
        {rsp.cyl, rsp.head, rsp.sect} = fit_geometry(req.cyl, req.head, req.sect);
      end
      default: begin
        // Alignment below 2 falls back to sectors per track.
        acc = (req.align < MIN_ALIGN) ? 64'(geo_spt) : 64'(req.align);
        if (acc == 0) begin
          rsp.fault = 1'b1;
        end else begin
          rem = 64'(req.lba) % acc;
          quo = acc + 64'(req.lba) - rem;
          rsp.lba = (rem != 0) ? quo[31:0] : req.lba;
        end
      end
    endcase
    return rsp;
  endfunction

  // ---------------------------------------------------------------------
  // Item construction
  // ---------------------------------------------------------------------

  function automatic addr_req_t mk_item(input func_e f, input logic [LBA_W-1:0] lba,
                                        input logic [CHS_W-1:0] c,
                                        input logic [CHS_W-1:0] h,
                                        input logic [CHS_W-1:0] s,
                                        input logic [LBA_W-1:0] a);
    addr_req_t r;
    r.func  = f;
    r.lba   = lba;
    r.cyl   = c;
    r.head  = h;
    r.sect  = s;
    r.align = a;
    return r;
  endfunction

  // CHS operand around a geometry limit: in range, on the edge, or anywhere.
  function automatic logic [CHS_W-1:0] pick_chs(input logic [CHS_W-1:0] lim);
    case ($urandom_range(0, 5))
      0:       return CHS_W'($urandom);
      1:       return lim;
      2:       return lim - 1'b1;
      3:       return CHS_W'($urandom_range(0, lim));
      default: return (lim == 0) ? '0 : CHS_W'($urandom_range(0, lim - 1));
    endcase
  endfunction

  function automatic logic [CHS_W-1:0] random_dim();
    case ($urandom_range(0, 7))
      0:       return '0;
      1, 2:    return CHS_W'($urandom_range(1, 8));
      3, 4, 5: return CHS_W'($urandom_range(9, 300));
      default: return CHS_W'($urandom);
    endcase
  endfunction

  function automatic addr_req_t random_item();
    addr_req_t   r;
    logic [63:0] span;
    logic [63:0] wide;
    r.func = func_e'($urandom_range(0, 3));
    // Total sectors of the disk; LBAs up to twice that reach the fold logic.
    span = 64'(geo_cyls) * 64'(geo_heads) * 64'(geo_spt);
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0:       r.lba = $urandom;
      1:       r.lba = $urandom_range(0, 4095);
      default: r.lba = (span == 0) ? $urandom : LBA_W'(wide % (span * 2 + 1));
    endcase
    r.cyl  = pick_chs(geo_cyls);
    r.head = pick_chs(geo_heads);
    r.sect = pick_chs(geo_spt);
    case ($urandom_range(0, 4))
      0:       r.align = $urandom_range(0, 1);
      1:       r.align = $urandom;
      2:       r.align = 32'd1 << $urandom_range(1, 31);
      default: r.align = $urandom_range(2, 5000);
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------

  // Offer one item after a random gap and record its prediction once taken.
  // Valid stays high after acceptance; the next call either swaps the
  // payload in the same step or drops valid for its gap.
  task automatic send_item(input addr_req_t req);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    func_drv  <= req.func;
    lba_drv   <= req.lba;
    cyl_drv   <= req.cyl;
    head_drv  <= req.head;
    sect_drv  <= req.sect;
    align_drv <= req.align;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_results.push_back(translate_addr(req));
  endtask

  // Stop offering and wait until every outstanding result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write enable is left high; set_geometry lowers it after the last write.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CHS_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_CYLINDERS: geo_cyls  = data;
      CFG_HEADS:     geo_heads = data;
      CFG_SECTORS:   geo_spt   = data;
      default: ;
    endcase
  endtask

  task automatic set_geometry(input logic [CHS_W-1:0] c, input logic [CHS_W-1:0] h,
                              input logic [CHS_W-1:0] s);
    drain_results();
    cfg_write(CFG_CYLINDERS, c);
    cfg_write(CFG_HEADS, h);
    cfg_write(CFG_SECTORS, s);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    addr_rsp_t want;
    if (pending_results.size() == 0) begin
      mismatch_count++;
      $display("%0t: result item with no input item outstanding", $time);
      return;
    end
    want = pending_results.pop_front();
    check_field("lba_out",      want.lba,       lba_out);
    check_field("cylinder_out", want.cyl,       cyl_out);
    check_field("head_out",     want.head,      head_out);
    check_field("sector_out",   want.sect,      sect_out);
    check_field("range_error",  want.range_err, range_err_out);
    check_field("divide_fault", want.fault,     fault_out);
  endtask

  // Receiver: per item, stall for a random count (or the one long hold),
  // then take the next result and check it.
  initial begin : result_sink
    int unsigned hold;
    wait (rst_n === 1'b1);
    forever begin
      if (long_hold_req) begin
        hold = LONG_HOLD;
        long_hold_req = 1'b0;
      end else if (no_idle) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 19);
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      check_result();
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset geometry 1024/255/63: field extremes and every op.
  task automatic test_default_geometry();
    send_item(mk_item(FUNC_TO_CHS, '0, '0, '0, '0, '0));
    send_item(mk_item(FUNC_TO_CHS, '1, '0, '0, '0, '0));          // cylinder truncates
    send_item(mk_item(FUNC_TO_CHS, 32'd16450560, '0, '0, '0, '0)); // cylinder == limit
    send_item(mk_item(FUNC_TO_LBA, '0, 16'd0, 16'd0, 16'd1, '0));
    send_item(mk_item(FUNC_TO_LBA, '0, 16'd1023, 16'd254, 16'd63, '0));
    send_item(mk_item(FUNC_TO_LBA, '1, '1, '1, '1, '1));          // all out of range
    send_item(mk_item(FUNC_TO_LBA, '0, 16'd5, 16'd3, 16'd0, '0)); // sector zero flags a range error
    send_item(mk_item(FUNC_ADJUST, '0, '1, '1, '1, '0));
    send_item(mk_item(FUNC_ADJUST, '0, 16'd2048, 16'd10, 16'd0, '0));
    send_item(mk_item(FUNC_ALIGN, 32'd100, '0, '0, '0, 32'd0));  // falls back to spt
    send_item(mk_item(FUNC_ALIGN, 32'd100, '0, '0, '0, 32'd1));
    send_item(mk_item(FUNC_ALIGN, '1, '0, '0, '0, 32'd16));       // rounds past 2^32
    send_item(mk_item(FUNC_ALIGN, 32'd64, '0, '0, '0, 32'd32));   // already aligned
    send_item(mk_item(FUNC_ALIGN, 32'd5, '0, '0, '0, '1));
  endtask

  // Zero divisors and zero-sized geometry.
  task automatic test_divide_faults();
    set_geometry(16'd1024, 16'd0, 16'd63);
    send_item(mk_item(FUNC_TO_CHS, 32'd12345, '0, '0, '0, '0));
    send_item(mk_item(FUNC_TO_LBA, '0, 16'd1, 16'd0, 16'd1, '0));
    set_geometry(16'd0, 16'd16, 16'd0);
    send_item(mk_item(FUNC_TO_CHS, 32'd777, '0, '0, '0, '0));
    send_item(mk_item(FUNC_ALIGN, 32'd99, '0, '0, '0, 32'd0));
    send_item(mk_item(FUNC_ALIGN, 32'd99, '0, '0, '0, 32'd1));
    send_item(mk_item(FUNC_ALIGN, 32'd99, '0, '0, '0, 32'd7));
    send_item(mk_item(FUNC_ADJUST, '0, 16'd5, 16'd3, 16'd9, '0));
  endtask

  // One cylinder, four heads: doubled head reaching the head count, the pin
  // to the last CHS, and a full sixteen-step fold from a zero head.
  task automatic test_fold_and_pin();
    set_geometry(16'd1, 16'd4, 16'd8);
    send_item(mk_item(FUNC_ADJUST, '0, 16'd3, 16'd1, 16'd2, '0));
    send_item(mk_item(FUNC_ADJUST, '0, 16'd3, 16'd3, 16'd9, '0));
    send_item(mk_item(FUNC_TO_CHS, 32'd1000, '0, '0, '0, '0));
    send_item(mk_item(FUNC_ADJUST, '0, '1, 16'd0, 16'd1, '0));
  endtask

  // Receiver holds off long enough that the block stalls its input, then
  // the sender pauses until everything has drained.
  task automatic test_backpressure();
    set_geometry(RST_CYLINDERS, RST_HEADS, RST_SECTORS);
    long_hold_req = 1'b1;
    no_idle = 1'b1;
    repeat (12) send_item(random_item());
    no_idle = 1'b0;
    drain_results();
    repeat (8) send_item(random_item());
  endtask

  // Random items over a series of geometries, extremes first.
  task automatic test_random_geometries();
    for (int p = 0; p < 10; p++) begin
      case (p)
        0:       set_geometry(RST_CYLINDERS, RST_HEADS, RST_SECTORS);
        1:       set_geometry('1, '1, '1);
        2:       set_geometry(16'd1, 16'd1, 16'd1);
        3:       set_geometry('0, '0, '0);
        4:       set_geometry('1, 16'd2, 16'd1);
        default: set_geometry(random_dim(), random_dim(), random_dim());
      endcase
      // a couple of phases run back to back with no gaps or stalls
      no_idle = (p == 2 || p == 7);
      repeat (110) send_item(random_item());
    end
    no_idle = 1'b0;
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_geometry();
    test_divide_faults();
    test_fold_and_pin();
    test_backpressure();
    test_random_geometries();
    drain_results();
    // catch any stray result after the last expected one
    repeat (120) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
